>>> rtl/alle_pkg.sv
`timescale 1ns / 1ps

package alle_pkg;

	// Number of slots, the sentinel included.
	localparam int LIST_SLOTS = 64;
	localparam int SW = $clog2(LIST_SLOTS);
	localparam int DW = 32;

	typedef enum logic [3:0] {
		OP_PUSH_FRONT  = 4'd0,
		OP_PUSH_BACK   = 4'd1,
		OP_INS_AFTER   = 4'd2,
		OP_INS_BEFORE  = 4'd3,
		OP_DELETE      = 4'd4,
		OP_READ_DATA   = 4'd5,
		OP_READ_NEXT   = 4'd6,
		OP_READ_PREV   = 4'd7,
		OP_SEARCH      = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD       = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD1  = 8'b0000_0010,
		S_RD2  = 8'b0000_0100,
		S_RD3  = 8'b0000_1000,
		S_WR1  = 8'b0001_0000,
		S_WR2  = 8'b0010_0000,
		S_SRCH = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	// Next link of a slot before it is first written: the free chain.
	function automatic logic [SW-1:0] reset_next(input logic [SW-1:0] idx);
		logic [SW-1:0] r;
		if (idx == '0 || idx == SW'(LIST_SLOTS - 1)) begin
			r = '0;
		end else begin
			r = idx + SW'(1);
		end
		return r;
	endfunction

endpackage

>>> rtl/alle_ram.sv
`timescale 1ns / 1ps

module alle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/array_linked_list_engine_top.sv
// Steps: reads go S_RD1, S_RD2, S_DONE; deletes add S_WR1 and S_WR2; pushes and inserts
// add S_RD3, S_WR1 and S_WR2; rejected requests go from S_RD1 to S_DONE; search walks S_SRCH.
// Throughput: one request at a time; a request is taken while a result still waits.
// The link and data memories have one read port each, which sets the step count.
// Reset (arst_n, asynchronous) empties the list: the free chain starts at slot 1,
// and valid bits stand for the reset contents of the link memories.
`timescale 1ns / 1ps

module array_linked_list_engine_top
	import alle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [3:0]           func,
	input  logic [SW-1:0]        slot,
	input  logic signed [DW-1:0] value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SW-1:0]        result_slot,
	output logic signed [DW-1:0] result_value,
	output logic [1:0]           status
);

	state_t             st_q;
	logic [3:0]         func_q;
	logic [SW-1:0]      slot_q;
	logic [DW-1:0]      value_q;
	logic [SW-1:0]      fh_q;
	logic [SW-1:0]      fnext_q;
	logic [SW-1:0]      i_q;
	logic [LIST_SLOTS-1:0] used_q;
	logic [LIST_SLOTS-1:0] nvld_q;
	logic [LIST_SLOTS-1:0] pvld_q;
	logic [SW-1:0]      nxt_s2;
	logic [SW-1:0]      prv_s2;
	logic [SW-1:0]      rs_q;
	logic [DW-1:0]      rv_q;
	status_t            rst_q;
	logic               out_valid_q;

	// Memory ports.
	logic               n_we, p_we, d_we;
	logic [SW-1:0]      n_waddr, p_waddr, d_waddr;
	logic [SW-1:0]      n_wdata, p_wdata;
	logic [SW-1:0]      n_raddr, p_raddr, d_raddr;
	logic [SW-1:0]      n_ram, p_ram;
	logic [DW-1:0]      d_ram;
	logic [SW-1:0]      n_ra_q;
	logic               n_v_q, p_v_q;
	logic [SW-1:0]      nx_rd, pv_rd;
	logic [SW-1:0]      a_w, b_w;
	logic               full, slot_ok, is_ins, in_acc, out_free;

	alle_ram #(.WIDTH(SW), .DEPTH(LIST_SLOTS)) u_next (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_ram)
	);

	alle_ram #(.WIDTH(SW), .DEPTH(LIST_SLOTS)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_ram)
	);

	alle_ram #(.WIDTH(DW), .DEPTH(LIST_SLOTS)) u_data (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(value_q),
		.raddr(d_raddr), .rdata(d_ram)
	);

	// Links that were never written read as their reset contents.
	assign nx_rd = n_v_q ? n_ram : reset_next(n_ra_q);
	assign pv_rd = p_v_q ? p_ram : '0;

	assign full     = (fh_q == '0);
	assign slot_ok  = used_q[slot_q];
	assign is_ins   = (func_q == OP_PUSH_FRONT) || (func_q == OP_PUSH_BACK) ||
	                  (func_q == OP_INS_AFTER) || (func_q == OP_INS_BEFORE);
	assign in_stall = (st_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Neighbours of the new slot: a before it, b after it.
	always_comb begin
		a_w = '0;
		b_w = '0;
		case (func_q)
			OP_PUSH_FRONT: begin
				b_w = nxt_s2;
			end
			OP_PUSH_BACK: begin
				a_w = prv_s2;
			end
			OP_INS_AFTER: begin
				a_w = slot_q;
				b_w = nxt_s2;
			end
			OP_INS_BEFORE: begin
				a_w = prv_s2;
				b_w = slot_q;
			end
			default: begin
				a_w = '0;
				b_w = '0;
			end
		endcase
	end

	// Read addresses for each step.
	always_comb begin
		n_raddr = fh_q;
		p_raddr = slot_q;
		d_raddr = slot_q;
		case (st_q)
			S_RD1: begin
				if (func_q == OP_PUSH_FRONT || func_q == OP_SEARCH) begin
					n_raddr = '0;
				end else begin
					n_raddr = slot_q;
				end
				if (func_q == OP_PUSH_BACK) begin
					p_raddr = '0;
				end
			end
			S_RD2, S_SRCH: begin
				if (func_q == OP_SEARCH) begin
					n_raddr = nx_rd;
					d_raddr = nx_rd;
				end
			end
			default: begin
				n_raddr = fh_q;
			end
		endcase
	end

	// Write ports for linking a new slot in or unlinking a deleted one.
	always_comb begin
		n_we    = 1'b0;
		p_we    = 1'b0;
		d_we    = 1'b0;
		n_waddr = '0;
		p_waddr = '0;
		d_waddr = fh_q;
		n_wdata = '0;
		p_wdata = '0;
		case (st_q)
			S_WR1: begin
				n_we = 1'b1;
				p_we = 1'b1;
				if (is_ins) begin
					d_we    = 1'b1;
					n_waddr = fh_q;
					n_wdata = b_w;
					p_waddr = fh_q;
					p_wdata = a_w;
				end else begin
					n_waddr = prv_s2;
					n_wdata = nxt_s2;
					p_waddr = nxt_s2;
					p_wdata = prv_s2;
				end
			end
			S_WR2: begin
				n_we = 1'b1;
				p_we = 1'b1;
				if (is_ins) begin
					n_waddr = a_w;
					n_wdata = fh_q;
					p_waddr = b_w;
					p_wdata = fh_q;
				end else begin
					n_waddr = slot_q;
					n_wdata = fh_q;
					p_waddr = slot_q;
					p_wdata = '0;
				end
			end
			default: begin
				n_we = 1'b0;
			end
		endcase
	end

	// Valid bits and the read tags that go with the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvld_q <= '0;
			pvld_q <= '0;
			n_v_q  <= 1'b0;
			p_v_q  <= 1'b0;
			n_ra_q <= '0;
		end else begin
			n_v_q  <= nvld_q[n_raddr];
			p_v_q  <= pvld_q[p_raddr];
			n_ra_q <= n_raddr;
			if (n_we) begin
				nvld_q[n_waddr] <= 1'b1;
			end
			if (p_we) begin
				pvld_q[p_waddr] <= 1'b1;
			end
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			fh_q        <= SW'(1);
			used_q      <= LIST_SLOTS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						st_q  <= S_RD1;
						rs_q  <= '0;
						rv_q  <= '0;
						rst_q <= ST_OK;
					end
				end
				S_RD1: begin
					case (func_q)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (full) begin
								rst_q <= ST_FULL;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_RD2;
							end
						end
						OP_INS_AFTER, OP_INS_BEFORE: begin
							if (!slot_ok) begin
								rst_q <= ST_BAD;
								st_q  <= S_DONE;
							end else if (full) begin
								rst_q <= ST_FULL;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_RD2;
							end
						end
						OP_DELETE: begin
							if (slot_q == '0 || !slot_ok) begin
								rst_q <= ST_BAD;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_RD2;
							end
						end
						OP_READ_DATA, OP_READ_NEXT, OP_READ_PREV: begin
							if (!slot_ok) begin
								rst_q <= ST_BAD;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_RD2;
							end
						end
						OP_SEARCH: begin
							st_q <= S_RD2;
						end
						default: begin
							st_q <= S_DONE;
						end
					endcase
				end
				S_RD2: begin
					nxt_s2 <= nx_rd;
					prv_s2 <= pv_rd;
					case (func_q)
						OP_READ_DATA: begin
							rv_q <= (slot_q != '0) ? d_ram : '0;
							st_q <= S_DONE;
						end
						OP_READ_NEXT: begin
							rs_q <= nx_rd;
							st_q <= S_DONE;
						end
						OP_READ_PREV: begin
							rs_q <= pv_rd;
							st_q <= S_DONE;
						end
						OP_SEARCH: begin
							i_q <= nx_rd;
							if (nx_rd == '0) begin
								rst_q <= ST_NOT_FOUND;
								st_q  <= S_DONE;
							end else begin
								st_q <= S_SRCH;
							end
						end
						OP_DELETE: begin
							st_q <= S_WR1;
						end
						default: begin
							st_q <= S_RD3;
						end
					endcase
				end
				S_RD3: begin
					fnext_q <= nx_rd;
					st_q    <= S_WR1;
				end
				S_WR1: begin
					st_q <= S_WR2;
					if (is_ins) begin
						used_q[fh_q] <= 1'b1;
					end
				end
				S_WR2: begin
					st_q <= S_DONE;
					if (is_ins) begin
						rs_q <= fh_q;
						fh_q <= fnext_q;
					end else begin
						used_q[slot_q] <= 1'b0;
						fh_q           <= slot_q;
					end
				end
				S_SRCH: begin
					if (d_ram == value_q) begin
						rs_q <= i_q;
						st_q <= S_DONE;
					end else if (nx_rd == '0) begin
						rst_q <= ST_NOT_FOUND;
						st_q  <= S_DONE;
					end else begin
						i_q <= nx_rd;
					end
				end
				S_DONE: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture and output beat registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= func;
			slot_q  <= slot;
			value_q <= value;
		end
		if (st_q == S_DONE && out_free) begin
			result_slot  <= rs_q;
			result_value <= rv_q;
			status       <= rst_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_sentinel_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q[0]) else $error("sentinel slot marked unused");
	a_free_head_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(fh_q != '0 && st_q != S_WR2) |-> !used_q[fh_q])
		else $error("free head slot in use");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (st_q == S_RD1)) else $error("accepted beat not started");
	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SRCH) |-> (i_q != '0)) else $error("search walked onto sentinel");
`endif

endmodule

>>> dv/tb_array_linked_list_engine_top.sv
`timescale 1ns / 1ps

module tb_array_linked_list_engine_top;
	import alle_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_BEATS = 2000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [SW-1:0] rslot;
		logic [DW-1:0] rvalue;
		logic [1:0]    rstatus;
	} list_reply_t;

	typedef struct {
		logic [3:0]    op;
		logic [SW-1:0] idx;
		logic [DW-1:0] val;
		logic          fixed;
		list_reply_t   reply;
	} request_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [3:0]           func;
	logic [SW-1:0]        slot;
	logic signed [DW-1:0] value;
	logic                 out_valid;
	logic                 out_stall;
	logic [SW-1:0]        result_slot;
	logic signed [DW-1:0] result_value;
	logic [1:0]           status;

	// Shadow copy of the list held by the block.
	logic [DW-1:0] shadow_data [LIST_SLOTS];
	logic [SW-1:0] shadow_next [LIST_SLOTS];
	logic [SW-1:0] shadow_prev [LIST_SLOTS];
	logic          shadow_used [LIST_SLOTS];
	logic [SW-1:0] shadow_free;

	list_reply_t pending_replies [$];
	request_row_t directed_rows [$];
	int error_count;
	int idle_cycles;
	logic hold_off;

	array_linked_list_engine_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.slot         (slot),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_slot  (result_slot),
		.result_value (result_value),
		.status       (status)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Empty list: only the sentinel is in use and the free chain runs from slot 1.
	task automatic clear_shadow();
		for (int i = 0; i < LIST_SLOTS; i++) begin
			shadow_data[i] = '0;
			shadow_next[i] = (i + 1 < LIST_SLOTS) ? SW'(i + 1) : '0;
			shadow_prev[i] = '0;
			shadow_used[i] = 1'b0;
		end
		shadow_next[0] = '0;
		shadow_used[0] = 1'b1;
		shadow_free = SW'(1);
	endtask

	// Takes the head of the free chain and links it between two slots.
	function automatic logic [SW-1:0] link_fresh(input logic [SW-1:0] a,
			input logic [SW-1:0] b, input logic [DW-1:0] v);
		logic [SW-1:0] n;
		n = shadow_free;
		shadow_free = shadow_next[n];
		shadow_data[n] = v;
		shadow_used[n] = 1'b1;
		shadow_next[n] = b;
		shadow_prev[n] = a;
		shadow_next[a] = n;
		shadow_prev[b] = n;
		return n;
	endfunction

	// Applies one request to the shadow list and gives the reply it should get.
	function automatic list_reply_t apply_request(input logic [3:0] op,
			input logic [SW-1:0] s, input logic [DW-1:0] v);
		list_reply_t r;
		logic full;
		logic [SW-1:0] p;
		logic [SW-1:0] n;
		logic [SW-1:0] i;
		int steps;
		r = '0;
		r.rstatus = ST_OK;
		full = (shadow_free == '0);
		case (op)
			OP_PUSH_FRONT: begin
				if (full) r.rstatus = ST_FULL;
				else r.rslot = link_fresh('0, shadow_next[0], v);
			end
			OP_PUSH_BACK: begin
				if (full) r.rstatus = ST_FULL;
				else r.rslot = link_fresh(shadow_prev[0], '0, v);
			end
			OP_INS_AFTER: begin
				if (!shadow_used[s]) r.rstatus = ST_BAD;
				else if (full) r.rstatus = ST_FULL;
				else r.rslot = link_fresh(s, shadow_next[s], v);
			end
			OP_INS_BEFORE: begin
				if (!shadow_used[s]) r.rstatus = ST_BAD;
				else if (full) r.rstatus = ST_FULL;
				else r.rslot = link_fresh(shadow_prev[s], s, v);
			end
			OP_DELETE: begin
				if (s == '0 || !shadow_used[s]) begin
					r.rstatus = ST_BAD;
				end else begin
					p = shadow_prev[s];
					n = shadow_next[s];
					shadow_next[p] = n;
					shadow_prev[n] = p;
					shadow_prev[s] = '0;
					shadow_next[s] = shadow_free;
					shadow_used[s] = 1'b0;
					shadow_free = s;
				end
			end
			OP_READ_DATA: begin
				if (!shadow_used[s]) r.rstatus = ST_BAD;
				else if (s != '0) r.rvalue = shadow_data[s];
			end
			OP_READ_NEXT: begin
				if (!shadow_used[s]) r.rstatus = ST_BAD;
				else r.rslot = shadow_next[s];
			end
			OP_READ_PREV: begin
				if (!shadow_used[s]) r.rstatus = ST_BAD;
				else r.rslot = shadow_prev[s];
			end
			OP_SEARCH: begin
				r.rstatus = ST_NOT_FOUND;
				i = shadow_next[0];
				steps = 0;
				while (i != '0 && steps < LIST_SLOTS) begin
					if (shadow_data[i] == v) begin
						r.rslot = i;
						r.rstatus = ST_OK;
						break;
					end
					i = shadow_next[i];
					steps++;
				end
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

	task automatic add_row(input logic [3:0] op, input int s, input logic [DW-1:0] v,
			input logic fixed, input list_reply_t reply);
		request_row_t row;
		row.op = op;
		row.idx = SW'(s);
		row.val = v;
		row.fixed = fixed;
		row.reply = reply;
		directed_rows.push_back(row);
	endtask

	// Sends one request beat after a random gap and records its expected reply.
	task automatic send_request(input logic [3:0] op, input logic [SW-1:0] s,
			input logic [DW-1:0] v, input logic fixed, input list_reply_t reply);
		list_reply_t predicted;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		slot <= s;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = apply_request(op, s, v);
		if (fixed && predicted != reply) begin
			$error("table row disagrees with shadow list: row %h shadow %h",
				reply, predicted);
			error_count++;
		end
		pending_replies.push_back(predicted);
		@(negedge clk);
	endtask

	// Picks a slot that is in use most of the time, otherwise any slot.
	function automatic logic [SW-1:0] pick_slot();
		logic [SW-1:0] s;
		if ($urandom_range(0, 9) < 8) begin
			for (int k = 0; k < 16; k++) begin
				s = SW'($urandom_range(1, LIST_SLOTS - 1));
				if (shadow_used[s]) return s;
			end
		end
		return SW'($urandom);
	endfunction

	// Draws values from a small pool half of the time so that searches find matches.
	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return DW'($urandom_range(0, 15));
			1: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Reply side: random stall per beat, one long hold-off, check in order.
	initial begin
		int wait_cycles;
		list_reply_t want;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else begin
				wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(negedge clk);
				end
				out_stall <= 1'b0;
				@(posedge clk);
				while (!out_valid) @(posedge clk);
				if (pending_replies.size() == 0) begin
					$error("reply beat with no request waiting");
					error_count++;
				end else begin
					want = pending_replies.pop_front();
					if (result_slot !== want.rslot) begin
						$error("result_slot expected %0d actual %0d", want.rslot, result_slot);
						error_count++;
					end
					if (result_value !== want.rvalue) begin
						$error("result_value expected %h actual %h", want.rvalue,
							result_value);
						error_count++;
					end
					if (status !== want.rstatus) begin
						$error("status expected %0d actual %0d", want.rstatus, status);
						error_count++;
					end
				end
			end
		end
	end

	// The receiver holds off for a long stretch early in the random part.
	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		repeat (1500) @(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		list_reply_t none;
		list_reply_t bad;
		list_reply_t r;
		logic [3:0] op;
		int roll;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = '0;
		slot = '0;
		value = '0;
		error_count = 0;
		idle_cycles = 0;
		clear_shadow();
		none = '0;
		bad = '0;
		bad.rstatus = ST_BAD;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty list cases, sentinel cases, extremes and unknown functions.
		r = '0; r.rstatus = ST_NOT_FOUND;
		add_row(OP_SEARCH, 0, 32'd0, 1'b1, r);
		add_row(OP_READ_NEXT, 0, 32'd0, 1'b1, none);
		add_row(OP_READ_PREV, 0, 32'd0, 1'b1, none);
		add_row(OP_READ_DATA, 0, 32'hffff_ffff, 1'b1, none);
		add_row(OP_DELETE, 0, 32'd0, 1'b1, bad);
		add_row(OP_READ_DATA, 63, 32'd0, 1'b1, bad);
		add_row(OP_INS_AFTER, 5, 32'd0, 1'b1, bad);
		add_row(OP_INS_BEFORE, 63, 32'd0, 1'b1, bad);
		add_row(OP_READ_NEXT, 1, 32'd0, 1'b1, bad);
		add_row(OP_READ_PREV, 1, 32'd0, 1'b1, bad);
		add_row(OP_DELETE, 1, 32'd0, 1'b1, bad);
		add_row(4'd9, 0, 32'd0, 1'b1, none);
		add_row(4'd15, 63, 32'hffff_ffff, 1'b1, none);
		r = '0; r.rslot = SW'(1);
		add_row(OP_PUSH_FRONT, 0, 32'h8000_0000, 1'b1, r);
		r.rslot = SW'(2);
		add_row(OP_PUSH_BACK, 63, 32'h7fff_ffff, 1'b1, r);
		add_row(OP_INS_AFTER, 0, 32'd5, 1'b0, none);
		add_row(OP_INS_BEFORE, 0, 32'd6, 1'b0, none);
		add_row(OP_INS_AFTER, 1, 32'd7, 1'b0, none);
		add_row(OP_INS_BEFORE, 2, 32'd8, 1'b0, none);
		add_row(OP_SEARCH, 0, 32'd6, 1'b0, none);
		add_row(OP_SEARCH, 0, 32'h7fff_ffff, 1'b0, none);
		add_row(OP_READ_DATA, 1, 32'd0, 1'b0, none);
		add_row(OP_READ_NEXT, 3, 32'd0, 1'b0, none);
		add_row(OP_DELETE, 3, 32'd0, 1'b0, none);
		add_row(OP_READ_PREV, 0, 32'd0, 1'b0, none);
		foreach (directed_rows[k]) begin
			send_request(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].val,
				directed_rows[k].fixed, directed_rows[k].reply);
		end

		// Fill the list to the brim, then push and insert into a full list.
		while (shadow_free != '0) begin
			send_request(OP_PUSH_BACK, SW'($urandom), pick_value(), 1'b0, none);
		end
		r = '0; r.rstatus = ST_FULL;
		send_request(OP_PUSH_FRONT, '0, 32'd1, 1'b1, r);
		send_request(OP_INS_AFTER, SW'(63), 32'd1, 1'b1, r);
		send_request(OP_INS_BEFORE, SW'(1), 32'd1, 1'b1, r);
		send_request(OP_SEARCH, '0, shadow_data[shadow_prev[0]], 1'b0, none);
		send_request(OP_READ_DATA, SW'(63), 32'd0, 1'b0, none);

		// Random part: the mix of adds and deletes drifts between sparse and full.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			roll = $urandom_range(0, 99);
			if ((n / 400) % 2 == 0) begin
				op = (roll < 45) ? OP_DELETE : 4'($urandom_range(0, 15));
			end else begin
				op = (roll < 45) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
			end
			send_request(op, pick_slot(), pick_value(), 1'b0, none);
		end
		in_valid <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
